[rtl/cdta_pkg.sv]
package cdta_pkg;

    // Widths of the internal words
    localparam int DIV_W     = 17;  // widest dividend: minute + carry + minute increment
    localparam int DIV_STEPS = 2;   // quotient, then remainder
    localparam int CNT_W     = 1;
    localparam int DAY_W     = 12;  // day before the month walk, up to 31 + 2778
    localparam int CARRY_W   = 12;  // largest carry between fields is 2778
    localparam int REM_W     = 6;

    // Reciprocal division: q = (x * ceil(2^23 / d)) >> 23, exact for any 17-bit x
    localparam int RCP_W     = 19;
    localparam int RCP_SHIFT = 23;
    localparam int PROD_W    = DIV_W + RCP_W;
    localparam int QUO_W     = PROD_W - RCP_SHIFT;

    localparam logic [REM_W-1:0] DIVISOR_SEC  = 6'd60;
    localparam logic [REM_W-1:0] DIVISOR_HOUR = 6'd24;
    localparam logic [REM_W-1:0] DIVISOR_YEAR = 6'd25;

    localparam logic [RCP_W-1:0] RECIP_SEC  = 19'd139811;
    localparam logic [RCP_W-1:0] RECIP_HOUR = 19'd349526;
    localparam logic [RCP_W-1:0] RECIP_YEAR = 19'd335545;

    localparam logic [13:0] YEAR_MAX = 14'h3FFF;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  YR25_LAST = 5'd24;

    // Source of the dividend for the shared divider
    typedef logic [1:0] t_src;
    localparam t_src SRC_YEAR = 2'd0;
    localparam t_src SRC_SEC  = 2'd1;
    localparam t_src SRC_MIN  = 2'd2;
    localparam t_src SRC_HOUR = 2'd3;

    typedef struct packed {
        logic load;   // capture a new word
        logic prep;   // load the divider
        logic step;   // one divider step
        logic wb;     // write quotient and remainder back
        logic walk;   // advance one month
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic div_last;   // the current step is the final one
        logic walk_done;  // day fits into the current month
    } t_sts;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            unique case (month)
                4'd2:                 len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                default:              len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

[rtl/cdta_ctrl.sv]
module cdta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cdta_pkg::t_sts i_sts,
    output cdta_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid
);
    import cdta_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_WALK = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    t_src       r_src, n_src;

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        o_cmd       = '0;
        o_cmd.src   = r_src;
        o_valid     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_src      = SRC_YEAR;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = ST_PREP;
                case (r_src)
                    SRC_YEAR: n_src = SRC_SEC;
                    SRC_SEC:  n_src = SRC_MIN;
                    SRC_MIN:  n_src = SRC_HOUR;
                    default:  n_state = ST_WALK;
                endcase
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= SRC_YEAR;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

endmodule

[rtl/cdta_dp.sv]
module cdta_dp (
    input  logic           i_clk,
    input  cdta_pkg::t_cmd i_cmd,
    output cdta_pkg::t_sts o_sts,
    input  logic [13:0]    i_year,
    input  logic [3:0]     i_month,
    input  logic [4:0]     i_day,
    input  logic [4:0]     i_hour,
    input  logic [5:0]     i_minute,
    input  logic [5:0]     i_second,
    input  logic [15:0]    i_inc_hours,
    input  logic [15:0]    i_inc_minutes,
    input  logic [15:0]    i_inc_seconds,
    output logic [13:0]    o_out_year,
    output logic [3:0]     o_out_month,
    output logic [4:0]     o_out_day,
    output logic [4:0]     o_out_hour,
    output logic [5:0]     o_out_minute,
    output logic [5:0]     o_out_second
);
    import cdta_pkg::*;

    logic [13:0]        r_year;
    logic [4:0]         r_yr25;     // year modulo 25
    logic [3:0]         r_month;
    logic [DAY_W-1:0]   r_day;
    logic [4:0]         r_hour;
    logic [5:0]         r_minute;
    logic [5:0]         r_second;
    logic [15:0]        r_add_h, r_add_m, r_add_s;
    logic [CARRY_W-1:0] r_carry;

    logic [DIV_W-1:0]   r_dvd;      // dividend, held through the division
    logic [RCP_W-1:0]   r_rcp;      // reciprocal of the divisor
    logic [QUO_W-1:0]   r_quo;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_dvs;
    logic [CNT_W-1:0]   r_cnt;

    logic [DIV_W-1:0]   dvd_init;
    logic [REM_W-1:0]   dvs_init;
    logic [RCP_W-1:0]   rcp_init;
    logic [PROD_W-1:0]  prod;
    logic [DIV_W-1:0]   quo_dvs;
    logic [DIV_W-1:0]   rem_full;
    logic               leap;
    logic [4:0]         len;

    always_comb begin
        case (i_cmd.src)
            SRC_YEAR: begin
                dvd_init = DIV_W'(r_year);
                dvs_init = DIVISOR_YEAR;
                rcp_init = RECIP_YEAR;
            end
            SRC_SEC: begin
                dvd_init = DIV_W'(r_second) + DIV_W'(r_add_s);
                dvs_init = DIVISOR_SEC;
                rcp_init = RECIP_SEC;
            end
            SRC_MIN: begin
                dvd_init = DIV_W'(r_minute) + DIV_W'(r_carry) + DIV_W'(r_add_m);
                dvs_init = DIVISOR_SEC;
                rcp_init = RECIP_SEC;
            end
            default: begin
                dvd_init = DIV_W'(r_hour) + DIV_W'(r_carry) + DIV_W'(r_add_h);
                dvs_init = DIVISOR_HOUR;
                rcp_init = RECIP_HOUR;
            end
        endcase
    end

    // Quotient by reciprocal multiply, remainder on the following step
    assign prod     = PROD_W'(r_dvd) * PROD_W'(r_rcp);
    assign quo_dvs  = DIV_W'(r_quo) * DIV_W'(r_dvs);
    assign rem_full = r_dvd - quo_dvs;

    // Leap: divisible by 4, and not by 100 unless also by 400
    assign leap = (r_year[1:0] == 2'b00) && ((r_yr25 != 5'd0) || (r_year[3:0] == 4'b0000));
    assign len  = month_len(r_month, leap);

    assign o_sts.div_last  = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.walk_done = (r_day <= DAY_W'(len));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year   <= i_year;
            r_month  <= ((i_month < MONTH_JAN) || (i_month > MONTH_DEC)) ? MONTH_JAN : i_month;
            r_day    <= DAY_W'(i_day);
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
            r_add_h  <= i_inc_hours;
            r_add_m  <= i_inc_minutes;
            r_add_s  <= i_inc_seconds;
            r_carry  <= '0;
        end
        if (i_cmd.prep) begin
            r_dvd <= dvd_init;
            r_dvs <= dvs_init;
            r_rcp <= rcp_init;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.step) begin
            if (r_cnt == '0) begin
                r_quo <= prod[RCP_SHIFT +: QUO_W];
            end else begin
                r_rem <= rem_full[REM_W-1:0];
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.wb) begin
            case (i_cmd.src)
                SRC_YEAR: r_yr25 <= r_rem[4:0];
                SRC_SEC: begin
                    r_second <= r_rem;
                    r_carry  <= r_quo[CARRY_W-1:0];
                end
                SRC_MIN: begin
                    r_minute <= r_rem;
                    r_carry  <= r_quo[CARRY_W-1:0];
                end
                default: begin
                    r_hour <= r_rem[4:0];
                    r_day  <= r_day + r_quo[DAY_W-1:0];
                end
            endcase
        end
        if (i_cmd.walk) begin
            r_day <= r_day - DAY_W'(len);
            if (r_month == MONTH_DEC) begin
                r_month <= MONTH_JAN;
                r_year  <= r_year + 14'd1;
                // 16383 wraps to 0, which is divisible by 25
                if ((r_year == YEAR_MAX) || (r_yr25 == YR25_LAST)) begin
                    r_yr25 <= '0;
                end else begin
                    r_yr25 <= r_yr25 + 5'd1;
                end
            end else begin
                r_month <= r_month + 4'd1;
            end
        end
    end

    assign o_out_year   = r_year;
    assign o_out_month  = r_month;
    assign o_out_day    = r_day[4:0];
    assign o_out_hour   = r_hour;
    assign o_out_minute = r_minute;
    assign o_out_second = r_second;

endmodule

[rtl/calendar_date_time_adder_top.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------------
// command  | in        | start high, busy low | i_year i_month i_day i_hour i_minute
//          |           |                      | i_second i_inc_hours i_inc_minutes i_inc_seconds
// result   | out       | o_valid, one cycle   | o_out_year o_out_month o_out_day o_out_hour
//          |           |                      | o_out_minute o_out_second
//
// After the accepting edge, a word goes through four divisions and a month walk before the
// result strobe; the walk crosses up to about 93 months of surplus days.
// Four divisions (year mod 25, seconds, minutes, hours) share one reciprocal
// multiplier; the month walk then retires one month per cycle.
// Reset (i_rst_n low at a clock edge) drops any word in flight and returns to idle.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module calendar_date_time_adder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    input  logic [15:0] i_inc_hours,
    input  logic [15:0] i_inc_minutes,
    input  logic [15:0] i_inc_seconds,
    output logic        o_valid,
    output logic [13:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [4:0]  o_out_hour,
    output logic [5:0]  o_out_minute,
    output logic [5:0]  o_out_second
);
    import cdta_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the load, the four divisions, the month walk and the strobe
    cdta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Hold the operands, the shared divider and the calendar registers
    cdta_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_inc_hours   (i_inc_hours),
        .i_inc_minutes (i_inc_minutes),
        .i_inc_seconds (i_inc_seconds),
        .o_out_year    (o_out_year),
        .o_out_month   (o_out_month),
        .o_out_day     (o_out_day),
        .o_out_hour    (o_out_hour),
        .o_out_minute  (o_out_minute),
        .o_out_second  (o_out_second)
    );

endmodule

[rtl/cdta_chk.sv]
module cdta_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [4:0]  o_out_hour,
    input logic [5:0]  o_out_minute,
    input logic [5:0]  o_out_second
);

    // An accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // A result only appears while a word is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // Busy drops only right after a result strobe
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> $past(o_valid))
        else $error("busy dropped without a result");

    // Time fields land in range whenever a result is strobed
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_hour < 5'd24) && (o_out_minute < 6'd60) && (o_out_second < 6'd60))
        else $error("result time out of range");

endmodule

bind calendar_date_time_adder_top cdta_chk u_cdta_chk (.*);

[verif/calendar_date_time_adder_top_tb.sv]
// Self-checking bench for the calendar date/time adder.
// Each start word carries a date, a time and an hour/minute/second offset.
// A local predictor computes the normalized date and time for every accepted
// word and queues it. Every o_valid strobe is compared field by field with the
// oldest queued stamp. The block cannot hold results off, so only the command
// side is throttled.
module calendar_date_time_adder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdta_pkg::*;

    localparam int CLK_HALF    = 6;          // 12 ns period
    localparam int RESET_LEN   = 9;
    localparam int SETTLE_LEN  = 200;        // exceeds the longest latency of a word
    localparam int CYCLE_LIMIT = 1_000_000;

    // One command word: start stamp plus the offset to add
    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] inc_hours;
        logic [15:0] inc_minutes;
        logic [15:0] inc_seconds;
    } t_req;

    // One result word: the normalized date and time
    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_stamp;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [13:0] i_year;
    logic [3:0]  i_month;
    logic [4:0]  i_day;
    logic [4:0]  i_hour;
    logic [5:0]  i_minute;
    logic [5:0]  i_second;
    logic [15:0] i_inc_hours;
    logic [15:0] i_inc_minutes;
    logic [15:0] i_inc_seconds;
    logic        o_valid;
    logic [13:0] o_out_year;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic [4:0]  o_out_hour;
    logic [5:0]  o_out_minute;
    logic [5:0]  o_out_second;

    // Stamps predicted for accepted words, oldest first
    t_stamp due_stamps[$];

    int unsigned words_accepted = 0;
    int unsigned stamps_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned sender_idle_pct = 0;

    calendar_date_time_adder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_inc_hours   (i_inc_hours),
        .i_inc_minutes (i_inc_minutes),
        .i_inc_seconds (i_inc_seconds),
        .o_valid       (o_valid),
        .o_out_year    (o_out_year),
        .o_out_month   (o_out_month),
        .o_out_day     (o_out_day),
        .o_out_hour    (o_out_hour),
        .o_out_minute  (o_out_minute),
        .o_out_second  (o_out_second)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Gregorian rule: every 4th year, except centuries not divisible by 400
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in(input int unsigned yr, input int unsigned mo);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mo == MONTH_FEB && is_leap(yr))
            return 29;
        return lens[(mo - 1) % 12];
    endfunction

    // Carry seconds into minutes, minutes into hours, hours into days, then
    // walk the surplus days off one month at a time.
    function automatic t_stamp add_offset(input t_req r);
        int unsigned yr, mo, dy, hr, mi, se, len;
        t_stamp res;
        yr = r.year;
        mo = r.month;
        dy = r.day;
        hr = r.hour;
        mi = r.minute;
        se = r.second;
        // An out-of-range month counts as January
        if (mo < MONTH_JAN || mo > MONTH_DEC)
            mo = MONTH_JAN;
        se = se + r.inc_seconds;
        mi = mi + se / 60;
        se = se % 60;
        mi = mi + r.inc_minutes;
        hr = hr + mi / 60;
        mi = mi % 60;
        hr = hr + r.inc_hours;
        dy = dy + hr / 24;
        hr = hr % 24;
        len = days_in(yr, mo);
        while (dy > len) begin
            dy = dy - len;
            mo = mo + 1;
            if (mo > MONTH_DEC) begin
                mo = MONTH_JAN;
                // The year wraps at the width of the port; leap rule uses the wrapped year
                yr = (yr + 1) & YEAR_MAX;
            end
            len = days_in(yr, mo);
        end
        res.year   = yr[13:0];
        res.month  = mo[3:0];
        res.day    = dy[4:0];
        res.hour   = hr[4:0];
        res.minute = mi[5:0];
        res.second = se[5:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitors: record accepted words, check every strobed result
    // ------------------------------------------------------------------

    // A word is taken at an edge where start is high and busy low
    always @(posedge i_clk) begin
        t_req taken;
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            taken.year        = i_year;
            taken.month       = i_month;
            taken.day         = i_day;
            taken.hour        = i_hour;
            taken.minute      = i_minute;
            taken.second      = i_second;
            taken.inc_hours   = i_inc_hours;
            taken.inc_minutes = i_inc_minutes;
            taken.inc_seconds = i_inc_seconds;
            due_stamps.push_back(add_offset(taken));
            words_accepted++;
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Results cannot be stalled: sample every edge the strobe is high
    always @(posedge i_clk) begin
        t_stamp exp_stamp;
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_valid)) begin
                $error("o_valid unknown after reset");
                mismatches++;
            end else if (o_valid) begin
                if (due_stamps.size() == 0) begin
                    $error("result strobe with no word outstanding: %0d-%0d-%0d %0d:%0d:%0d",
                           o_out_year, o_out_month, o_out_day,
                           o_out_hour, o_out_minute, o_out_second);
                    mismatches++;
                end else begin
                    exp_stamp = due_stamps.pop_front();
                    compare_field("out_year",   32'(exp_stamp.year),   32'(o_out_year));
                    compare_field("out_month",  32'(exp_stamp.month),  32'(o_out_month));
                    compare_field("out_day",    32'(exp_stamp.day),    32'(o_out_day));
                    compare_field("out_hour",   32'(exp_stamp.hour),   32'(o_out_hour));
                    compare_field("out_minute", 32'(exp_stamp.minute), 32'(o_out_minute));
                    compare_field("out_second", 32'(exp_stamp.second), 32'(o_out_second));
                    stamps_checked++;
                end
            end
        end
    end

    // Watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, due_stamps.size());
            $display("FAIL calendar_date_time_adder_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_req make_req(input int unsigned yr, input int unsigned mo,
                                      input int unsigned dy, input int unsigned hr,
                                      input int unsigned mi, input int unsigned se,
                                      input int unsigned ah, input int unsigned am,
                                      input int unsigned as_);
        t_req r;
        r.year        = yr[13:0];
        r.month       = mo[3:0];
        r.day         = dy[4:0];
        r.hour        = hr[4:0];
        r.minute      = mi[5:0];
        r.second      = se[5:0];
        r.inc_hours   = ah[15:0];
        r.inc_minutes = am[15:0];
        r.inc_seconds = as_[15:0];
        return r;
    endfunction

    // Mostly valid calendar stamps; the rest uses every bit of each field
    function automatic t_req random_req();
        t_req r;
        int unsigned pick;
        int unsigned yr, mo;
        logic [31:0] raw;
        pick = $urandom_range(99);
        if (pick < 85) begin
            yr = $urandom_range(9999);
            mo = $urandom_range(12, 1);
            r = make_req(yr, mo, $urandom_range(days_in(yr, mo), 1), $urandom_range(23),
                         $urandom_range(59), $urandom_range(59), 0, 0, 0);
        end else begin
            raw = $urandom();
            r.year   = raw[13:0];
            r.month  = raw[17:14];
            r.day    = raw[22:18];
            r.hour   = raw[27:23];
            raw = $urandom();
            r.minute = raw[5:0];
            r.second = raw[11:6];
        end
        // Offset size: small ones mostly stay in the month, large ones walk many months
        pick = $urandom_range(99);
        if (pick < 40) begin
            r.inc_hours   = 16'($urandom_range(99));
            r.inc_minutes = 16'($urandom_range(99));
            r.inc_seconds = 16'($urandom_range(99));
        end else if (pick < 75) begin
            r.inc_hours   = 16'($urandom_range(4095));
            r.inc_minutes = 16'($urandom_range(4095));
            r.inc_seconds = 16'($urandom_range(4095));
        end else begin
            r.inc_hours   = 16'($urandom_range(16'hFFFF));
            r.inc_minutes = 16'($urandom_range(16'hFFFF));
            r.inc_seconds = 16'($urandom_range(16'hFFFF));
        end
        return r;
    endfunction

    // Present one word and hold it until the block takes it. Start stays high
    // on return so back-to-back words need no extra edge.
    task automatic send_word(input t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_year        <= r.year;
        i_month       <= r.month;
        i_day         <= r.day;
        i_hour        <= r.hour;
        i_minute      <= r.minute;
        i_second      <= r.second;
        i_inc_hours   <= r.inc_hours;
        i_inc_minutes <= r.inc_minutes;
        i_inc_seconds <= r.inc_seconds;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start and hold off until every outstanding result has come back
    task automatic wait_for_drain();
        start <= 1'b0;
        while (due_stamps.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Leap years, month and year rollover, out-of-range fields, extremes
    task automatic test_calendar_corners();
        send_word(make_req(2024, 2, 28, 23, 59, 59, 0, 0, 1));      // into leap day
        send_word(make_req(2023, 2, 28, 23, 59, 59, 0, 0, 1));      // no leap day
        send_word(make_req(1900, 2, 28, 12, 0, 0, 24, 0, 0));       // century, not leap
        send_word(make_req(2000, 2, 28, 12, 0, 0, 24, 0, 0));       // divisible by 400
        send_word(make_req(2100, 2, 28, 0, 0, 0, 0, 1440, 0));
        send_word(make_req(2400, 2, 28, 0, 0, 0, 0, 0, 16'd43200));
        send_word(make_req(2023, 12, 31, 23, 59, 59, 0, 0, 1));     // new year
        send_word(make_req(9999, 12, 31, 23, 59, 59, 0, 0, 1));     // past the nominal range
        send_word(make_req(16383, 12, 31, 23, 59, 59, 0, 0, 1));    // year wraps to zero
        send_word(make_req(16383, 11, 30, 0, 0, 0, 16'hFFFF, 0, 0)); // wrap, then walk
        send_word(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));             // month zero, day zero
        send_word(make_req(0, 0, 0, 0, 0, 0, 24, 0, 0));            // day zero lifted by carry
        send_word(make_req(16383, 15, 31, 31, 63, 63,
                           16'hFFFF, 16'hFFFF, 16'hFFFF));          // every bit set
        send_word(make_req(2010, 13, 15, 8, 30, 0, 0, 0, 0));       // month thirteen
        send_word(make_req(2010, 4, 31, 0, 0, 0, 0, 0, 0));         // day past month end
        send_word(make_req(2011, 2, 31, 0, 0, 0, 0, 0, 0));
        send_word(make_req(2012, 6, 15, 31, 63, 63, 0, 0, 0));      // oversize time fields
        send_word(make_req(2000, 1, 1, 0, 0, 0, 16'hFFFF, 0, 0));
        send_word(make_req(2000, 1, 1, 0, 0, 0, 0, 16'hFFFF, 0));
        send_word(make_req(2000, 1, 1, 0, 0, 0, 0, 0, 16'hFFFF));
        send_word(make_req(2000, 1, 1, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(make_req(1999, 7, 4, 23, 59, 59, 0, 0, 0));       // zero offset
    endtask

    task automatic test_random_offsets(input int unsigned count, input int unsigned idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_word(random_req());
    endtask

    // Let the block go fully idle, then resume from a quiet start
    task automatic test_quiet_restart();
        wait_for_drain();
        repeat ($urandom_range(5, 1)) @(posedge i_clk);
        repeat (5)
            send_word(random_req());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_year        <= '0;
        i_month       <= '0;
        i_day         <= '0;
        i_hour        <= '0;
        i_minute      <= '0;
        i_second      <= '0;
        i_inc_hours   <= '0;
        i_inc_minutes <= '0;
        i_inc_seconds <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 17;
        test_calendar_corners();
        test_quiet_restart();
        test_random_offsets(300, 17);
        test_random_offsets(300, 53);
        test_quiet_restart();
        test_random_offsets(240, 0);

        // Drain, then allow a full latency for any stray strobe
        wait_for_drain();
        repeat (SETTLE_LEN) @(posedge i_clk);

        $display("%0d words taken, %0d results checked over %0d cycles", words_accepted,
                 stamps_checked, cycle_count);
        $display("covered leap/century rules, year wrap, out-of-range fields, full offsets");
        if (mismatches == 0 && due_stamps.size() == 0) begin
            $display("PASS calendar_date_time_adder_top");
        end else begin
            $display("FAIL calendar_date_time_adder_top");
        end
        $finish;
    end

endmodule
